// ===== rtl/core/dbc_pkg.sv =====
package dbc_pkg;

    // Configuration register indexes
    localparam logic [7:0] REG_RADIUS  = 8'd0;
    localparam logic [7:0] REG_MIN_PTS = 8'd1;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int RADIUS_W   = 32;
    localparam int MIN_PTS_W  = 7;

    localparam logic [RADIUS_W-1:0]  RADIUS_RESET  = 32'd10;
    localparam logic [MIN_PTS_W-1:0] MIN_PTS_RESET = 7'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic row_rd;
        logic row_init;
        logic row_cap;
        logic issue;
        logic row_wr;
        logic i_clr;
        logic i_inc;
        logic seed;
        logic fetch;
        logic take;
        logic pop;
        logic pop_rd;
        logic pop_wr;
        logic nc_inc;
        logic out_rd;
        logic clr_all;
    } dbc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic j_last;
        logic i_last;
        logic seed_ok;
        logic found;
        logic push_ok;
        logic sp_one;
    } dbc_sts_t;

endpackage

// ===== rtl/core/dbscan_cluster_1d.sv =====
// Points load at one per cycle; a transaction with tlast starts clustering.
// The neighbour table is built one pair a cycle through the point store read
// port. The seed scan checks each point in turn, and the depth-first walk moves
// through FETCH and EXP (POPR and POPW on a pop); results pass OUTA and OUTB.
// Synchronous active-low reset clears control state and the configuration
// registers; memories keep their contents, and unwritten entries are never used.
module dbscan_cluster_1d #(
    parameter int MAX_POINTS = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]        s_axis_tdata,  // point_value
    input  logic                                   s_axis_tlast,  // is_last
    // Result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // point_index, cluster_id, core_flag, zero padding
    output logic [(($clog2(MAX_POINTS)*2+2+7)/8)*8-1:0] m_axis_tdata,
    output logic                                   m_axis_tlast,  // last_result
    // Configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [dbc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [dbc_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import dbc_pkg::*;

    localparam int PW   = $clog2(MAX_POINTS);
    localparam int IDW  = PW + 1;
    localparam int OFW  = PW + IDW + 1;
    localparam int OUTW = ((OFW + 7) / 8) * 8;

    dbc_cmd_t cmd;
    dbc_sts_t sts;
    logic [PW-1:0]  out_index;
    logic [IDW-1:0] out_cluster;
    logic           out_core;
    logic           out_last;

    assign cfg_ready = 1'b1;

    dbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_accept (s_axis_tvalid && s_axis_tready),
        .s_last   (s_axis_tlast),
        .m_accept (m_axis_tvalid && m_axis_tready),
        .sts      (sts),
        .cmd      (cmd),
        .s_ready  (s_axis_tready),
        .m_valid  (m_axis_tvalid)
    );

    dbc_dp #(
        .MAX_POINTS (MAX_POINTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_point    (s_axis_tdata[VALUE_BITS-1:0]),
        .out_index   (out_index),
        .out_cluster (out_cluster),
        .out_core    (out_core),
        .out_last    (out_last)
    );

    assign m_axis_tdata = OUTW'({out_core, out_cluster, out_index});
    assign m_axis_tlast = out_last;

endmodule

// ===== rtl/core/dbc_ctrl.sv =====
module dbc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_accept,
    input  logic              s_last,
    input  logic              m_accept,
    input  dbc_pkg::dbc_sts_t sts,
    output dbc_pkg::dbc_cmd_t cmd,
    output logic              s_ready,
    output logic              m_valid
);
    import dbc_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD, ST_ROWA, ST_ROWB, ST_COMP, ST_DRAIN, ST_ROWW, ST_SCAN,
        ST_FETCH, ST_EXP, ST_POPR, ST_POPW, ST_SNEXT, ST_OUTA, ST_OUTB
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;

    // Next state and per-state commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    cmd.load = 1'b1;
                    if (s_last) begin
                        cmd.i_clr  = 1'b1;
                        state_next = ST_ROWA;
                    end
                end
            end
            ST_ROWA: begin
                cmd.row_rd   = 1'b1;
                cmd.row_init = 1'b1;
                state_next   = ST_ROWB;
            end
            ST_ROWB: begin
                cmd.row_cap = 1'b1;
                cmd.issue   = 1'b1;
                state_next  = sts.j_last ? ST_DRAIN : ST_COMP;
            end
            ST_COMP: begin
                cmd.issue = 1'b1;
                if (sts.j_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_ROWW;
            end
            ST_ROWW: begin
                cmd.row_wr = 1'b1;
                if (sts.i_last) begin
                    cmd.i_clr  = 1'b1;
                    state_next = ST_SCAN;
                end else begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_ROWA;
                end
            end
            ST_SCAN: begin
                if (sts.seed_ok) begin
                    cmd.seed   = 1'b1;
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_SNEXT;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_EXP;
            end
            ST_EXP: begin
                if (sts.found) begin
                    cmd.take = 1'b1;
                    if (sts.push_ok) begin
                        state_next = ST_FETCH;
                    end
                end else begin
                    cmd.pop = 1'b1;
                    if (sts.sp_one) begin
                        cmd.nc_inc = 1'b1;
                        state_next = ST_SNEXT;
                    end else begin
                        state_next = ST_POPR;
                    end
                end
            end
            ST_POPR: begin
                cmd.pop_rd = 1'b1;
                state_next = ST_POPW;
            end
            ST_POPW: begin
                cmd.pop_wr = 1'b1;
                state_next = ST_FETCH;
            end
            ST_SNEXT: begin
                if (sts.i_last) begin
                    cmd.i_clr  = 1'b1;
                    state_next = ST_OUTA;
                end else begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_OUTA: begin
                cmd.out_rd = 1'b1;
                state_next = ST_OUTB;
            end
            ST_OUTB: begin
                if (m_accept) begin
                    if (sts.i_last) begin
                        cmd.clr_all = 1'b1;
                        state_next  = ST_LOAD;
                    end else begin
                        cmd.i_inc  = 1'b1;
                        state_next = ST_OUTA;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
        s_ready_next = (state_next == ST_LOAD);
        m_valid_next = (state_next == ST_OUTB);
    end

    // State and registered handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/dbc_dp.sv =====
module dbc_dp #(
    parameter int MAX_POINTS = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dbc_pkg::dbc_cmd_t                     cmd,
    output dbc_pkg::dbc_sts_t                     sts,
    input  logic                                  cfg_wr,
    input  logic [dbc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dbc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [VALUE_BITS-1:0]          in_point,
    output logic [$clog2(MAX_POINTS)-1:0]         out_index,
    output logic [$clog2(MAX_POINTS):0]           out_cluster,
    output logic                                  out_core,
    output logic                                  out_last
);
    import dbc_pkg::*;

    localparam int PW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int IDW = PW + 1;
    localparam int DW  = VALUE_BITS + RADIUS_W + 1;

    // Configuration registers
    logic [RADIUS_W-1:0]  radius_reg;
    logic [MIN_PTS_W-1:0] min_pts_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= RADIUS_RESET;
            min_pts_reg <= MIN_PTS_RESET;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_RADIUS:  radius_reg  <= cfg_data[RADIUS_W-1:0];
                REG_MIN_PTS: min_pts_reg <= cfg_data[MIN_PTS_W-1:0];
                default: ;
            endcase
        end
    end

    // Counters and indexes
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] i_reg, j_reg, jq_reg, top_reg;
    logic          jv_reg;
    logic [CW-1:0] sp_reg;
    logic [IDW-1:0] nc_reg;
    logic [CW-1:0] ncnt_reg;
    logic          full;

    assign full = (cnt_reg == CW'(MAX_POINTS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            i_reg   <= '0;
            jv_reg  <= 1'b0;
            sp_reg  <= '0;
            nc_reg  <= '0;
        end else begin
            if (cmd.clr_all) begin
                cnt_reg <= '0;
            end else if (cmd.load && !full) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.i_clr || cmd.clr_all) begin
                i_reg <= '0;
            end else if (cmd.i_inc) begin
                i_reg <= i_reg + 1'b1;
            end
            jv_reg <= cmd.issue;
            if (cmd.seed) begin
                sp_reg <= CW'(1);
            end else if (cmd.take && sts.push_ok) begin
                sp_reg <= sp_reg + 1'b1;
            end else if (cmd.pop) begin
                sp_reg <= sp_reg - 1'b1;
            end
            if (cmd.clr_all) begin
                nc_reg <= '0;
            end else if (cmd.nc_inc) begin
                nc_reg <= nc_reg + 1'b1;
            end
        end
    end

    // Point store, one read port
    logic signed [VALUE_BITS-1:0] pt_mem [MAX_POINTS];
    logic signed [VALUE_BITS-1:0] pt_q_reg, a_reg;
    logic [PW-1:0] pt_addr;

    assign pt_addr = cmd.row_rd ? i_reg : j_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load && !full) begin
            pt_mem[cnt_reg[PW-1:0]] <= in_point;
        end
        pt_q_reg <= pt_mem[pt_addr];
    end

    // Pairwise distance test, one pair a cycle
    logic signed [VALUE_BITS:0] diff;
    logic [DW-1:0] mag;
    logic          hit;
    logic [MAX_POINTS-1:0] row_reg;

    assign diff = {a_reg[VALUE_BITS-1], a_reg} - {pt_q_reg[VALUE_BITS-1], pt_q_reg};
    assign mag  = diff[VALUE_BITS] ? DW'(-diff) : DW'(diff);
    assign hit  = (jq_reg != i_reg) && (mag <= DW'(radius_reg));

    always_ff @(posedge aclk) begin
        if (cmd.row_cap) begin
            a_reg <= pt_q_reg;
        end
        if (cmd.row_init) begin
            j_reg <= '0;
        end else if (cmd.issue) begin
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.issue) begin
            jq_reg <= j_reg;
        end
        if (cmd.row_init) begin
            row_reg  <= '0;
            ncnt_reg <= '0;
        end else if (jv_reg) begin
            row_reg[jq_reg] <= hit;
            ncnt_reg        <= ncnt_reg + CW'(hit);
        end
    end

    // Neighbour rows, core and visited flags
    logic [MAX_POINTS-1:0] nb_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] nb_q_reg;
    logic [MAX_POINTS-1:0] core_reg, vis_reg, cand;
    logic [PW-1:0] fj;
    logic          found;

    always_ff @(posedge aclk) begin
        if (cmd.row_wr) begin
            nb_mem[i_reg] <= row_reg;
        end
        if (cmd.fetch) begin
            nb_q_reg <= nb_mem[top_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            core_reg <= '0;
            vis_reg  <= '0;
        end else if (cmd.clr_all) begin
            core_reg <= '0;
            vis_reg  <= '0;
        end else begin
            if (cmd.row_wr) begin
                core_reg[i_reg] <= (32'(ncnt_reg) >= 32'(min_pts_reg));
            end
            if (cmd.seed) begin
                vis_reg[i_reg] <= 1'b1;
            end else if (cmd.take) begin
                vis_reg[fj] <= 1'b1;
            end
        end
    end

    // Lowest unvisited neighbour of the stack top
    assign cand = nb_q_reg & ~vis_reg;

    always_comb begin
        fj    = '0;
        found = 1'b0;
        for (int k = MAX_POINTS - 1; k >= 0; k--) begin
            if (cand[k]) begin
                fj    = PW'(k);
                found = 1'b1;
            end
        end
    end

    // Cluster numbers and walk stack
    logic [IDW-1:0] cl_mem [MAX_POINTS];
    logic [IDW-1:0] cl_q_reg;
    logic [PW-1:0]  st_mem [MAX_POINTS];
    logic [PW-1:0]  st_q_reg;
    logic [PW-1:0]  cl_waddr;

    assign cl_waddr = cmd.seed ? i_reg : fj;

    always_ff @(posedge aclk) begin
        if (cmd.seed || cmd.take) begin
            cl_mem[cl_waddr] <= nc_reg;
        end
        if (cmd.out_rd) begin
            cl_q_reg <= cl_mem[i_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.seed) begin
            st_mem[0] <= i_reg;
            top_reg   <= i_reg;
        end else if (cmd.take && sts.push_ok) begin
            st_mem[sp_reg[PW-1:0]] <= fj;
            top_reg                <= fj;
        end else if (cmd.pop_wr) begin
            top_reg <= st_q_reg;
        end
        if (cmd.pop_rd) begin
            st_q_reg <= st_mem[PW'(sp_reg - 1'b1)];
        end
    end

    // Status
    assign sts.j_last  = ({1'b0, j_reg} == CW'(cnt_reg - 1'b1));
    assign sts.i_last  = ({1'b0, i_reg} == CW'(cnt_reg - 1'b1));
    assign sts.seed_ok = core_reg[i_reg] && !vis_reg[i_reg];
    assign sts.found   = found;
    assign sts.push_ok = core_reg[fj] && (sp_reg != CW'(MAX_POINTS));
    assign sts.sp_one  = (sp_reg == CW'(1));

    // Result fields; an unvisited point is noise
    assign out_index   = i_reg;
    assign out_cluster = vis_reg[i_reg] ? cl_q_reg : '1;
    assign out_core    = core_reg[i_reg];
    assign out_last    = sts.i_last;

endmodule

// ===== rtl/core/dbc_checker.sv =====
module dbc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast,
    input logic [15:0] m_axis_tdata
);
    // Loading and result delivery never overlap.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is offered");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // After the final result the block is ready for a new set.
    a_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("not ready for loading after the final result");

    // Between results of one set no point is taken.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
        else $error("input ready in the middle of result delivery");

endmodule

bind dbscan_cluster_1d dbc_checker u_dbc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tdata  (m_axis_tdata[15:0])
);

// ===== tb/sv/dbscan_cluster_1d_checker.sv =====
`timescale 1ns / 100ps

// Watches the point, result and register channels of the clustering block.
// It keeps its own copy of the point set and registers, clusters each set
// when the final point arrives, and compares every result transaction.
module dbscan_cluster_1d_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    import dbc_pkg::*;

    localparam int NPTS = 64;

    typedef struct packed {
        logic [5:0]        point_index;
        logic signed [6:0] cluster_id;
        logic              core_flag;
        logic              last_result;
    } point_label_t;

    logic [31:0]        radius_q;
    logic [6:0]         min_pts_q;
    logic signed [31:0] set_points[NPTS];
    int                 set_size;
    point_label_t       labels_due[$];

    assign pending = labels_due.size();

    // Label every stored point, then queue one label per point in index order.
    function automatic void label_set();
        bit                nbr[NPTS][NPTS];
        bit                core[NPTS];
        bit                seen[NPTS];
        logic signed [6:0] cid[NPTS];
        int                walk[NPTS];
        int                sp, top, j, cnt, next_id;
        longint            d;
        point_label_t      lab;
        next_id = 0;
        for (int i = 0; i < set_size; i++) begin
            cnt = 0;
            seen[i] = 0;
            cid[i] = -7'sd1;
            for (int k = 0; k < set_size; k++) begin
                d = longint'(set_points[i]) - longint'(set_points[k]);
                if (d < 0) d = -d;
                nbr[i][k] = (i != k) && (d <= longint'({32'd0, radius_q}));
                cnt += nbr[i][k];
            end
            core[i] = (cnt >= min_pts_q);
        end
        for (int i = 0; i < set_size; i++) begin
            if (!seen[i] && core[i]) begin
                seen[i] = 1;
                cid[i] = next_id[6:0];
                sp = 0;
                walk[sp++] = i;
                // Depth-first growth: take the lowest unvisited neighbour.
                while (sp > 0) begin
                    top = walk[sp-1];
                    for (j = 0; j < set_size; j++)
                        if (nbr[top][j] && !seen[j]) break;
                    if (j >= set_size) begin
                        sp--;
                    end else begin
                        seen[j] = 1;
                        cid[j] = next_id[6:0];
                        if (core[j] && sp < NPTS) walk[sp++] = j;
                    end
                end
                next_id++;
            end
        end
        for (int i = 0; i < set_size; i++) begin
            lab.point_index = i[5:0];
            lab.cluster_id = cid[i];
            lab.core_flag = core[i];
            lab.last_result = (i == set_size - 1);
            labels_due = {labels_due, lab};
        end
        set_size = 0;
    endfunction

    always @(posedge aclk) begin
        point_label_t got, want;
        if (!aresetn) begin
            radius_q <= RADIUS_RESET;
            min_pts_q <= MIN_PTS_RESET;
            set_size = 0;
            fail_count <= 0;
        end else begin
            // Register write transaction.
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_RADIUS) radius_q <= cfg_data;
                else if (cfg_index == REG_MIN_PTS) min_pts_q <= cfg_data[6:0];
            end
            // Point transaction; a full store drops the point.
            if (s_axis_tvalid && s_axis_tready) begin
                if (set_size < NPTS) set_points[set_size++] = s_axis_tdata;
                if (s_axis_tlast) label_set();
            end
            // Result transaction.
            if (m_axis_tvalid && m_axis_tready) begin
                got.point_index = m_axis_tdata[5:0];
                got.cluster_id = m_axis_tdata[12:6];
                got.core_flag = m_axis_tdata[13];
                got.last_result = m_axis_tlast;
                if (labels_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: index %0d cluster %0d core %0b last %0b",
                                 got.point_index, got.cluster_id, got.core_flag,
                                 got.last_result);
                    fail_count <= fail_count + 1;
                end else begin
                    want = labels_due.pop_front();
                    if (got != want || m_axis_tdata[15:14] != 2'b00) begin
                        if (fail_count < 10)
                            $display({"mismatch: exp idx %0d cl %0d core %0b last %0b,",
                                      " got idx %0d cl %0d core %0b last %0b pad %b"},
                                     want.point_index, want.cluster_id, want.core_flag,
                                     want.last_result, got.point_index, got.cluster_id,
                                     got.core_flag, got.last_result, m_axis_tdata[15:14]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/dbscan_cluster_1d_tb.sv =====
`timescale 1ns / 100ps

module dbscan_cluster_1d_tb;
    import dbc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // point_value
    logic        s_axis_tlast;   // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;   // point_index, cluster_id, core_flag, zero padding
    logic        m_axis_tlast;   // last_result
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_count;
    int          stall_left;
    bit          quiet_mode;

    dbscan_cluster_1d u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    dbscan_cluster_1d_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 2);
    endfunction

    // Result-side back-pressure.
    always @(posedge aclk) begin
        if (quiet_mode || stall_left == 0) begin
            m_axis_tready <= 1'b1;
            if (!quiet_mode && $urandom_range(0, 3) == 0) stall_left <= gap_len();
        end else begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
    end

    // Watchdog on the cycle count.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("dbscan_cluster_1d test failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_point(input logic [31:0] value, input bit last);
        int gap;
        gap = quiet_mode ? 0 : gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        s_axis_tlast <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // Close the set, then wait for its labels and let the block settle.
    task automatic finish_set();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_set(input logic [31:0] pts[$]);
        foreach (pts[i]) send_point(pts[i], i == pts.size() - 1);
        finish_set();
    endtask

    initial begin
        logic [31:0] pts[$];
        logic [31:0] base;
        int          n, sent;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet_mode = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers, extreme coordinates and a small chain.
        pts = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd5, 32'd15, 32'hFFFF_FFFB,
                32'd100};
        send_set(pts);
        // Single-point set.
        pts = '{32'd7};
        send_set(pts);
        // Zero min_pts and zero radius: every point is core, equal points share a cluster.
        write_reg(REG_MIN_PTS, 32'd0);
        write_reg(REG_RADIUS, 32'd0);
        pts = '{32'd3, 32'd3, 32'd4, 32'hFFFF_FFFF};
        send_set(pts);
        // Widest radius with a min_pts above the set size: all noise.
        write_reg(REG_RADIUS, 32'hFFFF_FFFF);
        write_reg(REG_MIN_PTS, 32'd64);
        pts = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd1};
        send_set(pts);
        write_reg(REG_MIN_PTS, 32'd2);
        pts = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd1};
        send_set(pts);

        // Overfull store: points past the 64th are dropped.
        write_reg(REG_RADIUS, 32'd3);
        write_reg(REG_MIN_PTS, 32'd2);
        pts = {};
        for (int i = 0; i < 67; i++) pts = {pts, 32'($urandom_range(0, 120))};
        send_set(pts);

        // Random sets: mostly clustered coordinates, some anywhere.
        sent = 0;
        while (sent < 20) begin
            quiet_mode = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0) write_reg(REG_RADIUS, $urandom);
            else write_reg(REG_RADIUS, $urandom_range(0, 20));
            if ($urandom_range(0, 9) == 0) write_reg(REG_MIN_PTS, $urandom_range(0, 64));
            else write_reg(REG_MIN_PTS, $urandom_range(0, 4));
            n = $urandom_range(1, 14);
            base = $urandom;
            pts = {};
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 5) == 0) pts = {pts, 32'($urandom)};
                else pts = {pts, 32'(base + $urandom_range(0, 60))};
            end
            send_set(pts);
            sent += n;
        end

        if (fail_count == 0) begin
            $display("dbscan_cluster_1d test passed");
        end else begin
            $display("dbscan_cluster_1d test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dbc_pkg.sv
rtl/core/dbc_ctrl.sv
rtl/core/dbc_dp.sv
rtl/core/dbscan_cluster_1d.sv
rtl/core/dbc_checker.sv
tb/sv/dbscan_cluster_1d_checker.sv
tb/sv/dbscan_cluster_1d_tb.sv
